>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Clocked on i_clk; ASSERT_RST variants are masked while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/pwsd_pkg.sv
// Package for the priority work-stealing deque: defaults, codes, control structs.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pwsd_pkg;

    localparam int DEF_RING_SIZE       = 256;
    localparam int DEF_PRIORITY_LEVELS = 4;
    localparam int DEF_JOB_WIDTH       = 32;

    // item actions
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_PULL  = 2'd1;
    localparam logic [1:0] ACT_STEAL = 2'd2;
    localparam logic [1:0] ACT_BATCH = 2'd3;

    // result status
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic accept;   // latch the input item
        logic exec;     // update pointers, store and batch state
        logic load;     // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/priority_work_stealing_deque_top.sv
// An accepted item is latched, executed into the status register and the
// store's registered read port, then loaded into the output register. The next
// item may enter on that load; a stalled output holds the item at the response.
// Reset (i_rst_n low, synchronous): pointers, batch state and output valid clear.
// The job store is not cleared and takes no clearing pass.
`default_nettype none

module priority_work_stealing_deque_top
    import pwsd_pkg::*;
#(
    parameter int RING_SIZE       = DEF_RING_SIZE,       // slots per level, 2..65536
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS, // levels, 1..16
    parameter int JOB_WIDTH       = DEF_JOB_WIDTH        // stored job bits, 8..64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // item in
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [1:0]  i_priority_req,
    input  wire logic [31:0] i_job_in,
    input  wire logic [8:0]  i_batch_count,
    // result out
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_job_out
);

    // Controller steps each item through accept -> execute -> respond.
    // Execute updates the addressed level's top/bottom pointers and the
    // batch counters, and either writes the job at the bottom slot or
    // starts a read of the slot being pulled or stolen.
    // Respond hands status and job to the output register; the next item
    // may be accepted on that same edge.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    pwsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_dp_status (dp_status),
        .o_in_stall  (o_in_stall),
        .o_dp_cmd    (dp_cmd)
    );

    // Batch rule: the first item of a batch checks space for all of it;
    // a refused batch reports full on every item and writes nothing.
    pwsd_dp #(
        .RING_SIZE       (RING_SIZE),
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .JOB_WIDTH       (JOB_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .o_dp_status    (dp_status),
        .i_action       (i_action),
        .i_priority_req (i_priority_req),
        .i_job_in       (i_job_in),
        .i_batch_count  (i_batch_count),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_job_out      (o_job_out)
    );

endmodule

`default_nettype wire

>>> rtl/pwsd_ctrl.sv
// Sequencer of the deque: accept, execute, respond.
// Depends on pwsd_pkg; drives command struct to pwsd_dp.
`default_nettype none

module pwsd_ctrl
    import pwsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  t_dp_status      i_dp_status,
    output logic            o_in_stall,
    output t_dp_cmd         o_dp_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       can_accept;

    // a new item may enter while the previous result is handed over
    assign can_accept = (r_state == S_IDLE) ||
                        ((r_state == S_RESP) && i_dp_status.out_free);
    // no item is taken while reset is held
    assign o_in_stall = !can_accept || !i_rst_n;

    always_comb begin
        n_state         = r_state;
        o_dp_cmd.accept = i_in_valid && can_accept;
        o_dp_cmd.exec   = 1'b0;
        o_dp_cmd.load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_dp_cmd.exec = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_dp_status.out_free) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = i_in_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> rtl/pwsd_dp.sv
// Datapath of the deque: item register, per-level pointers, batch state,
// job store and output register. Depends on pwsd_pkg; driven by pwsd_ctrl.
`default_nettype none

module pwsd_dp
    import pwsd_pkg::*;
#(
    parameter int RING_SIZE       = DEF_RING_SIZE,
    parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
    parameter int JOB_WIDTH       = DEF_JOB_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_dp_cmd          i_dp_cmd,
    output t_dp_status       o_dp_status,
    input  wire logic [1:0]  i_action,
    input  wire logic [1:0]  i_priority_req,
    input  wire logic [31:0] i_job_in,
    input  wire logic [8:0]  i_batch_count,
    input  wire logic        i_out_stall,
    output logic             o_out_valid,
    output logic [1:0]       o_status,
    output logic [31:0]      o_job_out
);

    localparam int SPAN        = 2 * RING_SIZE;
    localparam int PTR_W       = $clog2(SPAN);
    localparam int SLOT_W      = $clog2(RING_SIZE);
    localparam int LVL_W       = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int STORE_DEPTH = PRIORITY_LEVELS * RING_SIZE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SUM_W       = ((PTR_W > 9) ? PTR_W : 9) + 1;

    localparam logic [PTR_W-1:0] SPAN_P = PTR_W'(SPAN);
    localparam logic [PTR_W-1:0] LAST_P = PTR_W'(SPAN - 1);
    localparam logic [PTR_W-1:0] RING_P = PTR_W'(RING_SIZE);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_P) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_P : p - PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] p);
        logic [SLOT_W-1:0] slot;
        slot = (p >= RING_P) ? SLOT_W'(p - RING_P) : SLOT_W'(p);
        return ADDR_W'(ADDR_W'(lvl) * ADDR_W'(RING_SIZE)) + ADDR_W'(slot);
    endfunction

    // latched item
    logic [1:0]           r_action;
    logic [1:0]           r_prio;
    logic [31:0]          r_job;
    logic [8:0]           r_count;

    logic [PTR_W-1:0]     r_top [PRIORITY_LEVELS];
    logic [PTR_W-1:0]     r_bot [PRIORITY_LEVELS];
    logic [8:0]           r_batch_left;
    logic                 r_batch_rej;

    logic [JOB_WIDTH-1:0] mem [STORE_DEPTH];
    logic [JOB_WIDTH-1:0] r_rdata;

    logic [1:0]           r_status;
    logic                 r_taken;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [31:0]          r_out_job;

    logic                 prio_ok;
    logic [LVL_W-1:0]     lvl;
    logic [PTR_W-1:0]     top_cur;
    logic [PTR_W-1:0]     bot_cur;
    logic [PTR_W-1:0]     used;
    logic                 full;
    logic                 empty;
    logic                 batch_first;
    logic [8:0]           cnt_eff;
    logic [SUM_W-1:0]     need;
    logic                 rej_new;
    logic                 rej_eff;

    logic                 top_we;
    logic [PTR_W-1:0]     top_wdata;
    logic                 bot_we;
    logic [PTR_W-1:0]     bot_wdata;
    logic                 mem_we;
    logic                 rd_en;
    logic [ADDR_W-1:0]    addr;
    logic [1:0]           n_status;
    logic                 n_taken;
    logic [8:0]           n_batch_left;
    logic                 n_batch_rej;

    assign prio_ok = (32'(r_prio) < PRIORITY_LEVELS);
    assign lvl     = LVL_W'(r_prio);
    assign top_cur = r_top[lvl];
    assign bot_cur = r_bot[lvl];
    assign used    = (bot_cur >= top_cur) ? (bot_cur - top_cur)
                                          : (bot_cur - top_cur + SPAN_P);
    assign full    = (used >= RING_P);
    assign empty   = (used == '0);

    assign batch_first = (r_batch_left == '0);
    assign cnt_eff     = (r_count == '0) ? 9'd1 : r_count;
    assign need        = SUM_W'(used) + SUM_W'(cnt_eff);
    assign rej_new     = !prio_ok || (need > SUM_W'(RING_SIZE));
    assign rej_eff     = batch_first ? rej_new : r_batch_rej;

    always_comb begin
        top_we       = 1'b0;
        top_wdata    = ptr_inc(top_cur);
        bot_we       = 1'b0;
        bot_wdata    = ptr_inc(bot_cur);
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        addr         = slot_addr(lvl, bot_cur);
        n_status     = ST_DONE;
        n_taken      = 1'b0;
        n_batch_left = r_batch_left;
        n_batch_rej  = r_batch_rej;
        case (r_action)
            ACT_PUSH: begin
                if (!prio_ok || full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    bot_we = 1'b1;
                end
            end
            ACT_PULL: begin
                if (!prio_ok || empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_taken = 1'b1;
                    addr    = slot_addr(lvl, ptr_dec(bot_cur));
                    // last job: top jumps to bottom, bottom stays
                    if (ptr_dec(bot_cur) == top_cur) begin
                        top_we    = 1'b1;
                        top_wdata = bot_cur;
                    end else begin
                        bot_we    = 1'b1;
                        bot_wdata = ptr_dec(bot_cur);
                    end
                end
            end
            ACT_STEAL: begin
                if (!prio_ok || empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_taken = 1'b1;
                    addr    = slot_addr(lvl, top_cur);
                    top_we  = 1'b1;
                end
            end
            ACT_BATCH: begin
                if (batch_first) begin
                    n_batch_left = cnt_eff - 9'd1;
                    n_batch_rej  = rej_new;
                end else begin
                    n_batch_left = r_batch_left - 9'd1;
                end
                if (rej_eff || !prio_ok || full) begin
                    n_status = ST_FULL;
                end else begin
                    mem_we = 1'b1;
                    bot_we = 1'b1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.accept) begin
            r_action <= i_action;
            r_prio   <= i_priority_req;
            r_job    <= i_job_in;
            r_count  <= i_batch_count;
        end
        if (i_dp_cmd.exec) begin
            r_status <= n_status;
            r_taken  <= n_taken;
        end
        if (i_dp_cmd.load) begin
            r_out_status <= r_status;
            r_out_job    <= r_taken ? 32'(r_rdata) : '0;
        end
    end

    // job store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec && mem_we) begin
            mem[addr] <= JOB_WIDTH'(r_job);
        end
        if (i_dp_cmd.exec && rd_en) begin
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_top[i] <= '0;
                r_bot[i] <= '0;
            end
            r_batch_left <= '0;
            r_batch_rej  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_dp_cmd.exec) begin
                if (top_we) begin
                    r_top[lvl] <= top_wdata;
                end
                if (bot_we) begin
                    r_bot[lvl] <= bot_wdata;
                end
                r_batch_left <= n_batch_left;
                r_batch_rej  <= n_batch_rej;
            end
            if (i_dp_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_dp_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_job_out            = r_out_job;

endmodule

`default_nettype wire

>>> rtl/pwsd_checker.sv
// Port-level checks for the deque top level, bound in below.
// Depends on pwsd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pwsd_checker
    import pwsd_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [1:0]  i_action,
    input wire logic [1:0]  i_priority_req,
    input wire logic [31:0] i_job_in,
    input wire logic [8:0]  i_batch_count,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_job_out
);

    logic [44:0] in_item;

    assign in_item = {i_action, i_priority_req, i_job_in, i_batch_count};

    // a stalled item keeps its fields
    `ASSERT_RST(a_in_hold, i_in_valid && o_in_stall |=> $stable(in_item), "stalled item moved")

    // a held result stays offered
    `ASSERT_RST(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result dropped")

    // a result with a failure status carries a zero job
    `ASSERT_RST(a_job_zero, o_out_valid && (o_status != ST_DONE) |-> (o_job_out == 32'd0), "job on fail")

    // an accepted item occupies the execute cycle
    `ASSERT_RST(a_exec_busy, i_in_valid && !o_in_stall |=> o_in_stall, "item accepted in execute")

    // reset empties the output register
    `ASSERT_ALWAYS(a_rst_out, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind priority_work_stealing_deque_top pwsd_checker u_pwsd_checker (.*);

`default_nettype wire
